// ===== sv/ber_tlv_header_parser_defines.svh =====
// ----------------------------------------------------------------------------
// BER TLV header parser assertion macros
// Shared concurrent assertion forms used by the parser RTL.
// ----------------------------------------------------------------------------
`ifndef BER_TLV_HEADER_PARSER_DEFINES_SVH
`define BER_TLV_HEADER_PARSER_DEFINES_SVH

// same-cycle implication
`define BTHP_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define BTHP_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== sv/bthp_pkg.sv =====
// ----------------------------------------------------------------------------
// BER TLV header parser package
// Result types, status codes and queue sizing shared by the parser modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package bthp_pkg;

   localparam int STATUS_W = 3;
   localparam int CLASS_W  = 2;
   localparam int TAG_W    = 13;
   localparam int LEN_W    = 32;

   localparam logic [STATUS_W-1:0] ST_OK          = 3'd0;
   localparam logic [STATUS_W-1:0] ST_EOF         = 3'd1;
   localparam logic [STATUS_W-1:0] ST_EOF_TAG     = 3'd2;
   localparam logic [STATUS_W-1:0] ST_EOF_LEN     = 3'd3;
   localparam logic [STATUS_W-1:0] ST_TAG_OVF     = 3'd4;
   localparam logic [STATUS_W-1:0] ST_LEN_OVF     = 3'd5;
   localparam logic [STATUS_W-1:0] ST_INDEF_PRIM  = 3'd6;
   localparam logic [STATUS_W-1:0] ST_TOO_DEEP    = 3'd7;

   localparam int QUEUE_DEPTH = 2;
   localparam int OUT_DATA_W  = 120;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [CLASS_W-1:0]  elem_class;
      logic                constructed;
      logic [TAG_W-1:0]    tag_number;
      logic                is_indefinite;
      logic [LEN_W-1:0]    header_len;
      logic [LEN_W-1:0]    content_len;
   } front_result_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage

// ===== sv/bthp_front.sv =====
// ----------------------------------------------------------------------------
// BER TLV header parser front end
// Takes one octet per beat, tracks identifier, length and nesting state,
// and pushes at most one header result per buffer into the queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "ber_tlv_header_parser_defines.svh"

module bthp_front #(
   parameter int MAX_DEPTH  = 16,
   parameter int LEN_OCTETS = 4
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        accept,
   input  logic [7:0]                  data_byte,
   input  logic                        last_byte,
   output logic                        push,
   output bthp_pkg::front_result_type  push_data
);

   localparam int DW = $clog2(MAX_DEPTH + 1);
   localparam int LW = $clog2(LEN_OCTETS + 1);

   localparam logic [2:0] PH_ID   = 3'd0;
   localparam logic [2:0] PH_TAGX = 3'd1;
   localparam logic [2:0] PH_LEN  = 3'd2;
   localparam logic [2:0] PH_LENX = 3'd3;
   localparam logic [2:0] PH_SKIP = 3'd4;
   localparam logic [2:0] PH_DONE = 3'd5;

   logic [2:0]                  phase_ff, phase_in;
   logic [31:0]                 pos_ff, pos_in;
   logic [bthp_pkg::TAG_W-1:0]  tag_ff, tag_in;
   logic [31:0]                 lacc_ff, lacc_in;
   logic [LW-1:0]               left_ff, left_in;
   logic [DW-1:0]               depth_ff, depth_in;
   logic [31:0]                 skip_ff, skip_in;
   logic                        eoc_ff, eoc_in;
   logic                        scan_ff, scan_in;
   logic [1:0]                  cls_ff, cls_in;
   logic                        form_ff, form_in;
   logic [1:0]                  ocls_ff, ocls_in;
   logic                        oform_ff, oform_in;
   logic [bthp_pkg::TAG_W-1:0]  otag_ff, otag_in;
   logic [31:0]                 ohlen_ff, ohlen_in;

   logic                        st_valid;
   logic [2:0]                  st_code;
   logic                        res_indef;
   logic [31:0]                 res_clen;
   logic                        hc_go;
   logic                        hc_indef;
   logic [31:0]                 hc_len;
   logic [bthp_pkg::TAG_W-1:0]  tag_or;
   logic [6:0]                  len_n;

   always_comb begin
      phase_in  = phase_ff;
      pos_in    = pos_ff;
      tag_in    = tag_ff;
      lacc_in   = lacc_ff;
      left_in   = left_ff;
      depth_in  = depth_ff;
      skip_in   = skip_ff;
      eoc_in    = eoc_ff;
      scan_in   = scan_ff;
      cls_in    = cls_ff;
      form_in   = form_ff;
      ocls_in   = ocls_ff;
      oform_in  = oform_ff;
      otag_in   = otag_ff;
      ohlen_in  = ohlen_ff;
      st_valid  = 1'b0;
      st_code   = bthp_pkg::ST_OK;
      res_indef = 1'b0;
      res_clen  = '0;
      hc_go     = 1'b0;
      hc_indef  = 1'b0;
      hc_len    = '0;
      push      = 1'b0;
      push_data = '0;
      tag_or    = tag_ff | {6'd0, data_byte[6:0]};
      len_n     = data_byte[6:0];

      if (accept && phase_ff != PH_DONE) begin
         pos_in = pos_ff + 32'd1;
         case (phase_ff)
            PH_ID: begin
               cls_in  = data_byte[7:6];
               form_in = data_byte[5];
               eoc_in  = (data_byte[7:6] == 2'd0);
               if (data_byte[4:0] == 5'h1f) begin
                  tag_in   = '0;
                  phase_in = PH_TAGX;
               end else begin
                  tag_in   = {8'd0, data_byte[4:0]};
                  phase_in = PH_LEN;
               end
            end
            PH_TAGX: begin
               tag_in = tag_or;
               if (!data_byte[7]) begin
                  phase_in = PH_LEN;
               end else if (tag_or[12:6] != 7'd0) begin
                  st_valid = 1'b1;
                  st_code  = bthp_pkg::ST_TAG_OVF;
               end else begin
                  tag_in = {tag_or[5:0], 7'd0};
               end
            end
            PH_LEN: begin
               if (data_byte[7]) begin
                  if (len_n > 7'(LEN_OCTETS)) begin
                     st_valid = 1'b1;
                     st_code  = bthp_pkg::ST_LEN_OVF;
                  end else if (len_n != 7'd0) begin
                     lacc_in  = '0;
                     left_in  = LW'(len_n);
                     phase_in = PH_LENX;
                  end else if (!form_ff) begin
                     st_valid = 1'b1;
                     st_code  = bthp_pkg::ST_INDEF_PRIM;
                  end else begin
                     hc_go    = 1'b1;
                     hc_indef = 1'b1;
                  end
               end else begin
                  hc_go  = 1'b1;
                  hc_len = {24'd0, data_byte};
               end
            end
            PH_LENX: begin
               lacc_in = {lacc_ff[23:0], data_byte};
               left_in = LW'(left_ff - LW'(1));
               if (left_ff == LW'(1)) begin
                  hc_go  = 1'b1;
                  hc_len = lacc_in;
               end
            end
            PH_SKIP: begin
               skip_in = skip_ff - 32'd1;
               if (skip_ff == 32'd1) begin
                  phase_in = PH_ID;
               end
            end
            default: begin
               phase_in = PH_ID;
            end
         endcase

         if (hc_go) begin
            if (!scan_ff) begin
               ocls_in  = cls_ff;
               oform_in = form_ff;
               otag_in  = tag_ff;
               ohlen_in = pos_in;
               if (!hc_indef) begin
                  st_valid = 1'b1;
                  res_clen = hc_len;
               end else begin
                  scan_in  = 1'b1;
                  depth_in = '0;
                  phase_in = PH_ID;
               end
            end else if (eoc_ff && tag_ff == '0) begin
               if (depth_ff == '0) begin
                  st_valid  = 1'b1;
                  res_indef = 1'b1;
                  res_clen  = pos_in - ohlen_ff;
               end else begin
                  depth_in = depth_ff - DW'(1);
                  phase_in = PH_ID;
               end
            end else if (hc_indef) begin
               if (depth_ff >= DW'(MAX_DEPTH)) begin
                  st_valid = 1'b1;
                  st_code  = bthp_pkg::ST_TOO_DEEP;
               end else begin
                  depth_in = depth_ff + DW'(1);
                  phase_in = PH_ID;
               end
            end else if (hc_len == 32'd0) begin
               phase_in = PH_ID;
            end else begin
               skip_in  = hc_len;
               phase_in = PH_SKIP;
            end
         end

         if (!st_valid && last_byte) begin
            st_valid = 1'b1;
            if (phase_in == PH_TAGX) begin
               st_code = bthp_pkg::ST_EOF_TAG;
            end else if (phase_in == PH_LEN || phase_in == PH_LENX) begin
               st_code = bthp_pkg::ST_EOF_LEN;
            end else begin
               st_code = bthp_pkg::ST_EOF;
            end
         end

         if (st_valid) begin
            push             = 1'b1;
            push_data.status = st_code;
            if (st_code == bthp_pkg::ST_OK) begin
               push_data.elem_class    = ocls_in;
               push_data.constructed   = oform_in;
               push_data.tag_number    = otag_in;
               push_data.is_indefinite = res_indef;
               push_data.header_len    = ohlen_in;
               push_data.content_len   = res_clen;
            end
            phase_in = PH_DONE;
         end
      end

      // end of buffer: start over on the next beat
      if (accept && last_byte) begin
         phase_in = PH_ID;
         pos_in   = '0;
         tag_in   = '0;
         lacc_in  = '0;
         left_in  = '0;
         depth_in = '0;
         skip_in  = '0;
         eoc_in   = 1'b0;
         scan_in  = 1'b0;
         cls_in   = '0;
         form_in  = 1'b0;
         ocls_in  = '0;
         oform_in = 1'b0;
         otag_in  = '0;
         ohlen_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_ID;
         pos_ff   <= '0;
         tag_ff   <= '0;
         lacc_ff  <= '0;
         left_ff  <= '0;
         depth_ff <= '0;
         skip_ff  <= '0;
         eoc_ff   <= 1'b0;
         scan_ff  <= 1'b0;
         cls_ff   <= '0;
         form_ff  <= 1'b0;
         ocls_ff  <= '0;
         oform_ff <= 1'b0;
         otag_ff  <= '0;
         ohlen_ff <= '0;
      end else begin
         phase_ff <= phase_in;
         pos_ff   <= pos_in;
         tag_ff   <= tag_in;
         lacc_ff  <= lacc_in;
         left_ff  <= left_in;
         depth_ff <= depth_in;
         skip_ff  <= skip_in;
         eoc_ff   <= eoc_in;
         scan_ff  <= scan_in;
         cls_ff   <= cls_in;
         form_ff  <= form_in;
         ocls_ff  <= ocls_in;
         oform_ff <= oform_in;
         otag_ff  <= otag_in;
         ohlen_ff <= ohlen_in;
      end
   end

   `BTHP_ASSERT_IMP(a_depth_bound, clock, reset, 1'b1, depth_ff <= DW'(MAX_DEPTH),
      "nesting depth above limit")
   `BTHP_ASSERT_IMP(a_done_silent, clock, reset, phase_ff == PH_DONE, !push,
      "result pushed after buffer already answered")
   `BTHP_ASSERT_NXT(a_last_clears, clock, reset, accept && last_byte,
      phase_ff == PH_ID && pos_ff == 32'd0 && !scan_ff, "state not cleared at buffer end")

endmodule

// ===== sv/bthp_queue.sv =====
// ----------------------------------------------------------------------------
// BER TLV header parser result queue
// Short register queue that decouples the parser from the output stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "ber_tlv_header_parser_defines.svh"

module bthp_queue (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        push,
   input  bthp_pkg::front_result_type  push_data,
   input  logic                        pop,
   output bthp_pkg::front_result_type  pop_data,
   output bthp_pkg::queue_status_type  qstat
);

   localparam int DEPTH = bthp_pkg::QUEUE_DEPTH;
   localparam int PW    = $clog2(DEPTH);
   localparam int CW    = $clog2(DEPTH + 1);

   bthp_pkg::front_result_type  mem_ff [DEPTH];
   logic [PW-1:0]               wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]               rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]               count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : PW'(wr_ptr_ff + PW'(1));
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : PW'(rd_ptr_ff + PW'(1));
      end
      if (push && !pop) begin
         count_in = count_ff + CW'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign pop_data    = mem_ff[rd_ptr_ff];
   assign qstat.full  = (count_ff == CW'(DEPTH));
   assign qstat.empty = (count_ff == '0);

   `BTHP_ASSERT_IMP(a_count_bound, clock, reset, 1'b1, count_ff <= CW'(DEPTH),
      "queue count above depth")
   `BTHP_ASSERT_IMP(a_no_overflow, clock, reset, push, !qstat.full, "push into full queue")
   `BTHP_ASSERT_IMP(a_no_underflow, clock, reset, pop, !qstat.empty, "pop from empty queue")

endmodule

// ===== sv/bthp_back.sv =====
// ----------------------------------------------------------------------------
// BER TLV header parser back end
// Pops queued results, forms the total advance and holds the output beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bthp_back (
   input  logic                                 clock,
   input  logic                                 reset,
   input  bthp_pkg::queue_status_type           qstat,
   input  bthp_pkg::front_result_type           pop_data,
   output logic                                 pop,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [bthp_pkg::OUT_DATA_W-1:0]      rsp_tdata
);

   logic                           valid_ff, valid_in;
   bthp_pkg::front_result_type     res_ff;
   logic [bthp_pkg::LEN_W-1:0]     total_ff;

   assign pop      = !qstat.empty && (!valid_ff || rsp_tready);
   assign valid_in = pop || (valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         res_ff   <= pop_data;
         total_ff <= pop_data.header_len + pop_data.content_len;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {4'd0, total_ff, res_ff.content_len, res_ff.header_len,
                        res_ff.is_indefinite, res_ff.tag_number, res_ff.constructed,
                        res_ff.elem_class, res_ff.status};

endmodule

// ===== sv/ber_tlv_header_parser.sv =====
// ----------------------------------------------------------------------------
// BER TLV header parser
// Decodes the outer BER identifier and length of each buffer, scans
// indefinite-length contents, and returns one header result per buffer.
// ----------------------------------------------------------------------------
// Throughput: one octet beat per cycle while the result queue is not full.
// Path: a result goes from the parser into the result queue, then into the
//    output register, which holds it until rsp_tready.
// Stalls: req_tready drops only while the two-entry result queue is full.
// Reset: synchronous, clears parser, queue and output state at once.
`timescale 1ns / 1ps

module ber_tlv_header_parser #(
   parameter int MAX_DEPTH  = 16,
   parameter int LEN_OCTETS = 4
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [7:0]                       req_tdata,   // data_byte
   input  logic                             req_tlast,   // last_byte
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // status[2:0], elem_class[4:3], constructed[5], tag_number[18:6],
   // is_indefinite[19], header_len[51:20], content_len[83:52],
   // total_len[115:84], zero fill[119:116]
   output logic [bthp_pkg::OUT_DATA_W-1:0]  rsp_tdata
);

   logic                        accept;
   logic                        push;
   logic                        pop;
   bthp_pkg::front_result_type  push_data;
   bthp_pkg::front_result_type  pop_data;
   bthp_pkg::queue_status_type  qstat;

   assign req_tready = !qstat.full;
   assign accept     = req_tvalid && req_tready;

   bthp_front #(
      .MAX_DEPTH  (MAX_DEPTH),
      .LEN_OCTETS (LEN_OCTETS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .data_byte (req_tdata),
      .last_byte (req_tlast),
      .push      (push),
      .push_data (push_data)
   );

   bthp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .pop_data  (pop_data),
      .qstat     (qstat)
   );

   bthp_back u_back (
      .clock      (clock),
      .reset      (reset),
      .qstat      (qstat),
      .pop_data   (pop_data),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// BER TLV header parser testbench
// Streams octet buffers into the parser: a few hand-built encodings for each
// status, then random well-formed, truncated and noise buffers under three
// idle profiles. A scoreboard predicts the header result of every buffer
// and checks each rsp beat field by field, in order.
// ----------------------------------------------------------------------------

localparam int TB_MAX_DEPTH  = 16;
localparam int TB_LEN_OCTETS = 4;
localparam int STALL_LIMIT   = 3000;
localparam int HOLD_CYCLES   = 400;
localparam int PRINT_CAP     = 100;

typedef enum logic [2:0] {
   P_IDENT, P_TAG_EXT, P_LEN, P_LEN_EXT, P_SKIP, P_DONE
} parse_phase_type;

typedef struct {
   logic [2:0]  status;
   logic [1:0]  elem_class;
   logic        constructed;
   logic [12:0] tag_number;
   logic        is_indefinite;
   logic [31:0] header_len;
   logic [31:0] content_len;
   logic [31:0] total_len;
} header_fields_type;

class header_scoreboard;
   parse_phase_type   phase;
   logic [31:0]       octet_count;
   logic [15:0]       tag_acc;
   logic [31:0]       len_acc;
   int unsigned       len_left;
   int unsigned       depth;
   logic [31:0]       skip_left;
   bit                eoc_like;
   bit                scanning;
   bit                sent;
   logic [1:0]        cur_class;
   logic              cur_form;
   logic [1:0]        outer_class;
   logic              outer_form;
   logic [12:0]       outer_tag;
   logic [31:0]       outer_hlen;
   header_fields_type expected_headers[$];
   int                mismatches;

   function new();
      clear_state();
      mismatches = 0;
   endfunction

   function void clear_state();
      phase       = P_IDENT;
      octet_count = '0;
      tag_acc     = '0;
      len_acc     = '0;
      len_left    = 0;
      depth       = 0;
      skip_left   = '0;
      eoc_like    = 1'b0;
      scanning    = 1'b0;
      sent        = 1'b0;
      cur_class   = '0;
      cur_form    = 1'b0;
      outer_class = '0;
      outer_form  = 1'b0;
      outer_tag   = '0;
      outer_hlen  = '0;
   endfunction

   function int pending();
      return expected_headers.size();
   endfunction

   // end of a complete identifier + length; returns a status or -1 to go on
   function int finish_header(input bit indef, input logic [31:0] len,
                              output bit res_indef, output logic [31:0] res_clen);
      res_indef = 1'b0;
      res_clen  = '0;
      if (!scanning) begin
         outer_class = cur_class;
         outer_form  = cur_form;
         outer_tag   = tag_acc[12:0];
         outer_hlen  = octet_count;
         if (!indef) begin
            res_clen = len;
            return bthp_pkg::ST_OK;
         end
         scanning = 1'b1;
         depth    = 0;
         phase    = P_IDENT;
         return -1;
      end
      if (eoc_like && tag_acc == 16'd0) begin
         if (depth == 0) begin
            res_indef = 1'b1;
            res_clen  = octet_count - outer_hlen;
            return bthp_pkg::ST_OK;
         end
         depth--;
         phase = P_IDENT;
         return -1;
      end
      if (indef) begin
         if (depth >= TB_MAX_DEPTH) return bthp_pkg::ST_TOO_DEEP;
         depth++;
         phase = P_IDENT;
         return -1;
      end
      if (len == 32'd0) begin
         phase = P_IDENT;
      end else begin
         skip_left = len;
         phase     = P_SKIP;
      end
      return -1;
   endfunction

   function void note_octet(input logic [7:0] b, input logic last);
      int                st;
      bit                res_indef;
      logic [31:0]       res_clen;
      logic [6:0]        n;
      header_fields_type r;
      st        = -1;
      res_indef = 1'b0;
      res_clen  = '0;
      if (phase == P_DONE || sent) begin
         if (last) clear_state();
         return;
      end
      octet_count = octet_count + 32'd1;
      case (phase)
         P_IDENT: begin
            cur_class = b[7:6];
            cur_form  = b[5];
            eoc_like  = (b[7:6] == 2'd0);
            if (b[4:0] == 5'h1f) begin
               tag_acc = '0;
               phase   = P_TAG_EXT;
            end else begin
               tag_acc = {11'd0, b[4:0]};
               phase   = P_LEN;
            end
         end
         P_TAG_EXT: begin
            tag_acc = tag_acc | {9'd0, b[6:0]};
            if (!b[7]) phase = P_LEN;
            else if (tag_acc[12:6] != 7'd0) st = bthp_pkg::ST_TAG_OVF;
            else tag_acc = tag_acc << 7;
         end
         P_LEN: begin
            if (b[7]) begin
               n = b[6:0];
               if (n > TB_LEN_OCTETS) begin
                  st = bthp_pkg::ST_LEN_OVF;
               end else if (n > 0) begin
                  len_acc  = '0;
                  len_left = n;
                  phase    = P_LEN_EXT;
               end else if (!cur_form) begin
                  st = bthp_pkg::ST_INDEF_PRIM;
               end else begin
                  st = finish_header(1'b1, 32'd0, res_indef, res_clen);
               end
            end else begin
               st = finish_header(1'b0, {24'd0, b}, res_indef, res_clen);
            end
         end
         P_LEN_EXT: begin
            len_acc = {len_acc[23:0], b};
            if (len_left > 0) len_left--;
            if (len_left == 0) st = finish_header(1'b0, len_acc, res_indef, res_clen);
         end
         default: begin
            if (skip_left > 0) skip_left = skip_left - 32'd1;
            if (skip_left == 0) phase = P_IDENT;
         end
      endcase
      if (st < 0 && last) begin
         if (phase == P_TAG_EXT) st = bthp_pkg::ST_EOF_TAG;
         else if (phase == P_LEN || phase == P_LEN_EXT) st = bthp_pkg::ST_EOF_LEN;
         else st = bthp_pkg::ST_EOF;
      end
      if (st < 0) return;
      r = '{default: '0};
      r.status = st[2:0];
      if (st == bthp_pkg::ST_OK) begin
         r.elem_class    = outer_class;
         r.constructed   = outer_form;
         r.tag_number    = outer_tag;
         r.is_indefinite = res_indef;
         r.header_len    = outer_hlen;
         r.content_len   = res_clen;
         r.total_len     = outer_hlen + res_clen;
      end
      expected_headers.push_back(r);
      if (last) begin
         clear_state();
      end else begin
         phase = P_DONE;
         sent  = 1'b1;
      end
   endfunction

   task report(input string msg);
      if (mismatches < PRINT_CAP) $display("mismatch: %s", msg);
      mismatches++;
   endtask

   task check_header(input logic [bthp_pkg::OUT_DATA_W-1:0] d);
      header_fields_type got;
      header_fields_type want;
      got.status        = d[2:0];
      got.elem_class    = d[4:3];
      got.constructed   = d[5];
      got.tag_number    = d[18:6];
      got.is_indefinite = d[19];
      got.header_len    = d[51:20];
      got.content_len   = d[83:52];
      got.total_len     = d[115:84];
      if (expected_headers.size() == 0) begin
         report($sformatf("unexpected rsp beat, status %0d", got.status));
         return;
      end
      want = expected_headers.pop_front();
      if (got.status !== want.status)
         report($sformatf("status %0d, want %0d", got.status, want.status));
      if (got.elem_class !== want.elem_class)
         report($sformatf("elem_class %0d, want %0d", got.elem_class, want.elem_class));
      if (got.constructed !== want.constructed)
         report($sformatf("constructed %0d, want %0d", got.constructed, want.constructed));
      if (got.tag_number !== want.tag_number)
         report($sformatf("tag_number %0d, want %0d", got.tag_number, want.tag_number));
      if (got.is_indefinite !== want.is_indefinite)
         report($sformatf("is_indefinite %0d, want %0d", got.is_indefinite,
                          want.is_indefinite));
      if (got.header_len !== want.header_len)
         report($sformatf("header_len %0d, want %0d", got.header_len, want.header_len));
      if (got.content_len !== want.content_len)
         report($sformatf("content_len %0d, want %0d", got.content_len, want.content_len));
      if (got.total_len !== want.total_len)
         report($sformatf("total_len %0d, want %0d", got.total_len, want.total_len));
   endtask
endclass

module testbench;

   logic                            clock      = 1'b0;
   logic                            reset      = 1'b1;
   logic                            req_tvalid = 1'b0;
   logic                            req_tready;
   logic [7:0]                      req_tdata  = '0;
   logic                            req_tlast  = 1'b0;
   logic                            rsp_tvalid;
   logic                            rsp_tready = 1'b0;
   logic [bthp_pkg::OUT_DATA_W-1:0] rsp_tdata;

   int send_idle    = 35;
   int recv_idle    = 54;
   int hold_token   = 0;
   int hold_seen    = 0;
   int hold_left    = 0;
   int stall_cycles = 0;
   int beats_sent   = 0;

   logic [7:0] frame[$];

   header_scoreboard headers = new();

   always #5 clock = ~clock;

   ber_tlv_header_parser #(
      .MAX_DEPTH  (TB_MAX_DEPTH),
      .LEN_OCTETS (TB_LEN_OCTETS)
   ) i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // receiver: random backpressure, long hold-off on request
   always @(posedge clock) begin
      if (hold_token != hold_seen) begin
         hold_seen = hold_token;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_idle);
      end
   end

   // beat monitor and watchdog
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) headers.note_octet(req_tdata, req_tlast);
         if (rsp_tvalid && rsp_tready) headers.check_header(rsp_tdata);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) stall_cycles = 0;
         else stall_cycles++;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("FAILURE");
            $finish;
         end
      end
   end

   task automatic send_frame();
      for (int i = 0; i < frame.size(); i++) begin
         if ($urandom_range(99) < send_idle) begin
            req_tvalid <= 1'b0;
            do @(posedge clock); while ($urandom_range(99) < send_idle);
         end
         req_tvalid <= 1'b1;
         req_tdata  <= frame[i];
         req_tlast  <= (i == frame.size() - 1);
         @(posedge clock);
         while (!req_tready) @(posedge clock);
         beats_sent++;
      end
      frame.delete();
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (headers.pending() != 0);
      repeat (4) @(posedge clock);
   endtask

   function automatic void put_random(input int count);
      repeat (count) frame.push_back(8'($urandom_range(255)));
   endfunction

   function automatic logic [12:0] rand_tag();
      case ($urandom_range(3))
         0:       return 13'($urandom_range(31, 127));
         1:       return 13'($urandom_range(128, 8191));
         default: return 13'($urandom_range(0, 30));
      endcase
   endfunction

   function automatic void put_ident(input logic [1:0] cls, input logic form,
                                     input logic [12:0] tag);
      if (tag < 31 && $urandom_range(3) != 0) begin
         frame.push_back({cls, form, tag[4:0]});
      end else begin
         frame.push_back({cls, form, 5'h1f});
         if (tag >= 128) frame.push_back({2'b10, tag[12:7]});
         frame.push_back({1'b0, tag[6:0]});
      end
   endfunction

   // inner identifier that is never taken for end-of-contents
   function automatic void put_inner_ident(input logic form);
      logic [1:0]  cls;
      logic [12:0] tag;
      cls = 2'($urandom_range(3));
      tag = rand_tag();
      if (cls == 2'd0 && tag == 13'd0) tag = 13'd1;
      put_ident(cls, form, tag);
   endfunction

   function automatic void put_length(input logic [31:0] len);
      int n;
      if (len < 128 && $urandom_range(2) != 0) begin
         frame.push_back(len[7:0]);
      end else begin
         n = (len > 32'hFFFFFF) ? 4 : (len > 32'hFFFF) ? 3 : (len > 32'hFF) ? 2 : 1;
         if (n < TB_LEN_OCTETS && $urandom_range(3) == 0) n++;
         frame.push_back(8'h80 | 8'(n));
         for (int k = n - 1; k >= 0; k--) frame.push_back(len[8*k +: 8]);
      end
   endfunction

   // end-of-contents; its length octets carry no meaning
   function automatic void put_eoc();
      if ($urandom_range(7) == 0) begin
         frame.push_back(8'h1f);
         frame.push_back(8'h00);
      end else begin
         frame.push_back(8'h00);
      end
      case ($urandom_range(5))
         0: begin
            frame.push_back(8'h81);
            frame.push_back(8'($urandom_range(255)));
         end
         1:       frame.push_back(8'($urandom_range(127)));
         default: frame.push_back(8'h00);
      endcase
   endfunction

   function automatic void build_definite();
      logic [31:0] len;
      int          body;
      put_ident(2'($urandom_range(3)), 1'($urandom_range(1)), rand_tag());
      case ($urandom_range(3))
         0:       len = $urandom;
         1:       len = $urandom_range(0, 127);
         2:       len = $urandom_range(128, 65535);
         default: len = $urandom_range(0, 6);
      endcase
      put_length(len);
      body = (len < 6) ? int'(len) : $urandom_range(0, 6);
      put_random(body);
      if ($urandom_range(3) == 0) put_random($urandom_range(1, 4));
   endfunction

   function automatic void build_indefinite();
      int open;
      int cnt;
      open = 0;
      put_ident(2'($urandom_range(3)), 1'b1, rand_tag());
      frame.push_back(8'h80);
      if ($urandom_range(14) == 0) begin
         repeat ($urandom_range(14, 18)) begin
            put_inner_ident(1'b1);
            frame.push_back(8'h80);
            open++;
         end
      end
      repeat ($urandom_range(0, 6)) begin
         case ($urandom_range(5))
            0, 1: begin
               put_inner_ident(1'b1);
               frame.push_back(8'h80);
               open++;
            end
            2: begin
               if (open > 0) begin
                  put_eoc();
                  open--;
               end
            end
            3: begin
               if ($urandom_range(9) == 0) begin
                  put_inner_ident(1'b0);
                  frame.push_back(8'h80);
               end
            end
            default: begin
               cnt = $urandom_range(0, 5);
               put_inner_ident(1'($urandom_range(1)));
               put_length(32'(cnt));
               put_random(cnt);
            end
         endcase
      end
      repeat (open + 1) put_eoc();
      if ($urandom_range(3) == 0) put_random($urandom_range(1, 4));
   endfunction

   function automatic void build_frame();
      int pick;
      int keep;
      pick = $urandom_range(99);
      if (pick < 10) begin
         put_random($urandom_range(1, 10));
      end else begin
         if (pick < 40) build_definite();
         else build_indefinite();
         if (pick >= 85) begin
            keep = $urandom_range(1, frame.size());
            while (frame.size() > keep) void'(frame.pop_back());
         end
      end
   endfunction

   task automatic run_phase(input int s_idle, input int r_idle, input int beats,
                            input bit with_hold);
      int target;
      target    = beats_sent + beats;
      send_idle = s_idle;
      recv_idle = r_idle;
      if (with_hold) hold_token++;
      while (beats_sent < target) begin
         build_frame();
         send_frame();
      end
      wait_drained();
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // short primitive
      frame = '{8'h02, 8'h01, 8'h05};
      send_frame();
      // widest length, total wraps, trailing octets ignored
      frame = '{8'hFF, 8'h7F, 8'h84, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hAA, 8'h55};
      send_frame();
      // largest two-octet tag, long length
      frame = '{8'h5F, 8'hBF, 8'h7F, 8'h82, 8'h01, 8'h00};
      send_frame();
      // zero length, last on the length octet
      frame = '{8'h80, 8'h00};
      send_frame();
      // length count too wide
      frame = '{8'h30, 8'h85, 8'h00};
      send_frame();
      // tag overflow
      frame = '{8'h1F, 8'hFF, 8'h81};
      send_frame();
      // buffer ends inside tag, inside length, before length
      frame = '{8'h1F, 8'h81};
      send_frame();
      frame = '{8'h04, 8'h82, 8'h01};
      send_frame();
      frame = '{8'h00};
      send_frame();
      // buffer ends while skipping, and before an inner identifier
      frame = '{8'h30, 8'h80, 8'h02, 8'h05, 8'h01};
      send_frame();
      frame = '{8'h24, 8'h80, 8'h30, 8'h80};
      send_frame();
      // indefinite primitive, outer and inner
      frame = '{8'h04, 8'h80};
      send_frame();
      frame = '{8'h30, 8'h80, 8'h24, 8'h80, 8'h04, 8'h80};
      send_frame();
      // nested indefinite, closing end-of-contents with a long length
      frame = '{8'h30, 8'h80, 8'hA1, 8'h80, 8'h02, 8'h01, 8'h07, 8'h00, 8'h00,
                8'h00, 8'h81, 8'h03, 8'hEE};
      send_frame();
      // end-of-contents with a multi-octet zero tag
      frame = '{8'h30, 8'h80, 8'h1F, 8'h00, 8'h00};
      send_frame();
      // one level past the depth limit
      frame = '{8'h30, 8'h80};
      repeat (TB_MAX_DEPTH + 1) begin
         frame.push_back(8'hA0);
         frame.push_back(8'h80);
      end
      send_frame();
      wait_drained();

      run_phase(35, 54, 620, 1'b0);
      run_phase(54, 35, 620, 1'b0);
      run_phase(0, 0, 620, 1'b1);

      repeat (10) @(posedge clock);
      if (headers.mismatches == 0 && headers.pending() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
+incdir+sv
sv/bthp_pkg.sv
sv/bthp_front.sv
sv/bthp_queue.sv
sv/bthp_back.sv
sv/ber_tlv_header_parser.sv
bench/testbench.sv
